// ===== rtl/epst_pkg.sv =====
// Package for the echo probe statistics table: payload structs, command codes,
// the front-to-back queue entry and reset constants. No dependencies.
package epst_pkg;

  localparam int unsigned MaxSlotsDefault = 8;
  localparam int unsigned HalveAtDefault  = 16;
  localparam logic [15:0] ResetPeriod     = 16'd3000;
  localparam logic [15:0] ResetSpread     = 16'd100;
  localparam logic [3:0]  ResetActive     = 4'd8;

  typedef enum logic [2:0] {
    CMD_SET_ADDR = 3'd0,
    CMD_TICK     = 3'd1,
    CMD_SEND     = 3'd2,
    CMD_REPLY    = 3'd3,
    CMD_QUERY    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    REG_ACTIVE = 2'd0,
    REG_BASE   = 2'd1,
    REG_PERIOD = 2'd2,
    REG_SPREAD = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV_RATE,
    ST_DIV_LAT,
    ST_OUT
  } back_state_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  slot;
    logic [31:0] ip_addr;
    logic [31:0] now_ms;
    logic [7:0]  echo_type;
    logic [15:0] echo_ident;
    logic [15:0] echo_seq;
    logic        send_ok;
  } in_item_t;

  typedef struct packed {
    logic [15:0] wait_ms;
    logic        send_request;
    logic [31:0] dest_addr;
    logic [2:0]  request_slot;
    logic [15:0] out_ident;
    logic [15:0] out_seq;
    logic        reply_accepted;
    logic [6:0]  rate_pct;
    logic [31:0] latency_avg_ms;
    logic [15:0] probes_sent;
    logic [15:0] probes_ok;
    logic [15:0] send_failures;
  } out_item_t;

  // Classified item handed from front to back.
  typedef struct packed {
    in_item_t   item;
    logic       valid_slot;   // slot (or reply slot) is in use
    logic [2:0] eff_slot;     // slot the command works on
  } work_t;

endpackage

// ===== rtl/epst_front.sv =====
// Front part: accepts input items, classifies them and pushes them into a
// two-entry queue toward the back part. Depends on epst_pkg.
module epst_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  epst_pkg::in_item_t in_item_i,
  input  logic [3:0]       n_used_i,
  input  logic [15:0]      base_id_i,
  output logic             q_valid_o,
  output epst_pkg::work_t  q_data_o,
  input  logic             q_pop_i
);

  epst_pkg::work_t mem_q [2];
  logic            wr_q, rd_q;
  logic [1:0]      cnt_q;
  epst_pkg::work_t w;
  logic [15:0]     rslot;
  logic            acc;

  always_comb begin
    rslot = in_item_i.echo_ident - base_id_i;
    w.item = in_item_i;
    if (in_item_i.cmd == epst_pkg::CMD_REPLY) begin
      w.eff_slot   = rslot[2:0];
      w.valid_slot = (rslot < {12'd0, n_used_i});
    end else begin
      w.eff_slot   = in_item_i.slot;
      w.valid_slot = ({1'b0, in_item_i.slot} < n_used_i);
    end
  end

  assign full      = (cnt_q == 2'd2);
  assign acc       = push && !full;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (acc) mem_q[wr_q] <= w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (acc) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, acc} - {1'b0, q_pop_i};
    end
  end

endmodule

// ===== rtl/epst_div.sv =====
// Radix-2 restoring divider for 32-bit unsigned operands, one bit a cycle.
// No dependencies.
module epst_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        busy_o,
  output logic [31:0] quo_o
);

  logic [31:0] quo_q, den_q;
  logic [31:0] rem_q;
  logic [5:0]  cnt_q;
  logic [32:0] sh, diff;

  assign sh     = {rem_q, quo_q[31]};
  assign diff   = sh - {1'b0, den_q};
  assign busy_o = (cnt_q != 6'd0);
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i; den_q <= den_i; rem_q <= 32'd0;
    end else if (busy_o) begin
      // For a nonzero divisor the partial remainder stays below it, so 32 bits hold it.
      if (!diff[32]) begin
        rem_q <= diff[31:0]; quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= sh[31:0]; quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 6'd0;
    end else if (start_i) begin
      cnt_q <= 6'd32;
    end else if (busy_o) begin
      cnt_q <= cnt_q - 6'd1;
    end
  end

endmodule

// ===== rtl/epst_back.sv =====
// Back part: per-slot statistics table, round sequencing and query division.
// Depends on epst_pkg and epst_div.
module epst_back #(
  parameter int unsigned MaxSlots = epst_pkg::MaxSlotsDefault,
  parameter int unsigned HalveAt  = epst_pkg::HalveAtDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  epst_pkg::work_t  q_data_i,
  output logic             q_pop_o,
  input  logic [3:0]       n_used_i,
  input  logic [15:0]      base_id_i,
  input  logic [15:0]      period_i,
  input  logic [15:0]      spread_i,
  output logic             empty,
  input  logic             pop,
  output epst_pkg::out_item_t out_item_o
);

  localparam int unsigned SW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;

  logic [31:0] tgt_q   [MaxSlots];
  logic [15:0] sent_q  [MaxSlots];
  logic [15:0] succ_q  [MaxSlots];
  logic [31:0] dly_q   [MaxSlots];
  logic [15:0] fail_q  [MaxSlots];
  logic [15:0] lseq_q  [MaxSlots];
  logic [31:0] lms_q   [MaxSlots];
  logic [MaxSlots-1:0] aw_q;
  logic [3:0]  pos_q;
  logic [15:0] rseq_q;

  epst_pkg::back_state_e st_q, st_d;
  epst_pkg::work_t       w_q;
  epst_pkg::out_item_t   res_q;
  epst_pkg::out_item_t   res_exec;
  logic                  full_q;

  logic        dstart;
  logic [31:0] dnum, dden, dquo;
  logic        dbusy;

  epst_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(dstart),
    .num_i(dnum), .den_i(dden), .busy_o(dbusy), .quo_o(dquo)
  );

  logic [SW-1:0] s, p;
  logic [15:0]   sent_inc, fail_inc, succ_inc, divr;
  logic [31:0]   used, dsum;
  logic          rate_ok, halve_f, halve_r;

  assign s = w_q.eff_slot[SW-1:0];
  assign p = pos_q[SW-1:0];
  assign empty   = !full_q;
  assign out_item_o = res_q;

  always_comb begin
    sent_inc = (sent_q[s] == 16'hFFFF) ? sent_q[s] : sent_q[s] + 16'd1;
    fail_inc = (fail_q[s] == 16'hFFFF) ? fail_q[s] : fail_q[s] + 16'd1;
    succ_inc = (succ_q[s] == 16'hFFFF) ? succ_q[s] : succ_q[s] + 16'd1;
    used     = {28'd0, n_used_i} * {16'd0, spread_i};
    dsum     = dly_q[s] + (w_q.item.now_ms - lms_q[s]);
    divr     = sent_q[s] - {15'd0, aw_q[s]};
    rate_ok  = sent_q[s] > {15'd0, aw_q[s]};
    halve_f  = {16'd0, sent_q[s]} >= 32'(HalveAt);
    halve_r  = halve_f;
  end

  // Result fields that are known once the command has been looked at.
  always_comb begin
    res_exec = '0;
    case (w_q.item.cmd)
      epst_pkg::CMD_TICK: begin
        if (pos_q >= n_used_i) begin
          res_exec.wait_ms = (used >= {16'd0, period_i}) ? 16'd0 : period_i - used[15:0];
        end else begin
          res_exec.wait_ms = spread_i;
          if (tgt_q[p] != 32'd0) begin
            res_exec.send_request = 1'b1;
            res_exec.dest_addr    = tgt_q[p];
            res_exec.request_slot = 3'(pos_q);
            res_exec.out_ident    = base_id_i + {12'd0, pos_q};
            res_exec.out_seq      = rseq_q;
          end
        end
      end
      epst_pkg::CMD_REPLY: begin
        if (w_q.item.echo_type == 8'd0 && w_q.valid_slot &&
            lseq_q[s] == w_q.item.echo_seq && tgt_q[s] == w_q.item.ip_addr && aw_q[s])
          res_exec.reply_accepted = 1'b1;
      end
      epst_pkg::CMD_QUERY: begin
        if (w_q.valid_slot) begin
          res_exec.probes_sent   = sent_q[s];
          res_exec.probes_ok     = succ_q[s];
          res_exec.send_failures = fail_q[s];
        end
      end
      default: ;
    endcase
  end

  // Next state. A new item is taken only once the previous result has been read.
  always_comb begin
    st_d = st_q;
    case (st_q)
      epst_pkg::ST_IDLE: if (q_valid_i && !full_q) st_d = epst_pkg::ST_EXEC;
      epst_pkg::ST_EXEC: begin
        if (w_q.item.cmd == epst_pkg::CMD_QUERY && w_q.valid_slot)
          st_d = epst_pkg::ST_DIV_RATE;
        else st_d = epst_pkg::ST_OUT;
      end
      epst_pkg::ST_DIV_RATE: if (!dbusy) st_d = epst_pkg::ST_DIV_LAT;
      epst_pkg::ST_DIV_LAT:  if (!dbusy) st_d = epst_pkg::ST_OUT;
      epst_pkg::ST_OUT: if (!full_q) st_d = epst_pkg::ST_IDLE;
      default: st_d = epst_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    q_pop_o = (st_q == epst_pkg::ST_IDLE) && q_valid_i && !full_q;
    dstart  = 1'b0;
    dnum    = 32'd0;
    dden    = 32'd1;
    case (st_q)
      epst_pkg::ST_EXEC: begin
        dstart = (w_q.item.cmd == epst_pkg::CMD_QUERY) && w_q.valid_slot;
        dnum   = {16'd0, succ_q[s]} * 32'd100;
        dden   = {16'd0, divr};
      end
      epst_pkg::ST_DIV_RATE: begin
        // The rate quotient is taken in this cycle and the latency pass starts.
        dstart = !dbusy;
        dnum   = dly_q[s];
        dden   = {16'd0, succ_q[s]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) w_q <= q_data_i;
    if (st_q == epst_pkg::ST_EXEC) res_q <= res_exec;
    if (st_q == epst_pkg::ST_DIV_RATE && !dbusy)
      res_q.rate_pct <= !rate_ok ? 7'd0 : (dquo > 32'd100) ? 7'd100 : dquo[6:0];
    if (st_q == epst_pkg::ST_DIV_LAT && !dbusy)
      res_q.latency_avg_ms <= (succ_q[s] == 16'd0) ? 32'd0 : dquo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= epst_pkg::ST_IDLE;
      full_q <= 1'b0;
      pos_q <= 4'd0;
      rseq_q <= 16'd0;
      aw_q <= '0;
      for (int i = 0; i < MaxSlots; i++) begin
        tgt_q[i] <= '0; sent_q[i] <= '0; succ_q[i] <= '0; dly_q[i] <= '0;
        fail_q[i] <= '0; lseq_q[i] <= '0; lms_q[i] <= '0;
      end
    end else begin
      st_q <= st_d;
      if (pop && full_q) full_q <= 1'b0;
      if (st_q == epst_pkg::ST_OUT && !full_q) full_q <= 1'b1;
      if (st_q == epst_pkg::ST_EXEC) begin
        case (w_q.item.cmd)
          epst_pkg::CMD_SET_ADDR: begin
            if (w_q.valid_slot && tgt_q[s] != w_q.item.ip_addr) begin
              tgt_q[s] <= w_q.item.ip_addr;
              sent_q[s] <= '0; succ_q[s] <= '0; dly_q[s] <= '0;
              fail_q[s] <= '0; lseq_q[s] <= '0; lms_q[s] <= '0; aw_q[s] <= 1'b0;
            end
          end
          epst_pkg::CMD_TICK: begin
            if (pos_q >= n_used_i) begin
              rseq_q <= rseq_q + 16'd1;
              pos_q <= 4'd0;
            end else begin
              pos_q <= pos_q + 4'd1;
            end
          end
          epst_pkg::CMD_SEND: begin
            if (w_q.valid_slot) begin
              if (w_q.item.send_ok) begin
                lms_q[s] <= w_q.item.now_ms;
                lseq_q[s] <= rseq_q;
                sent_q[s] <= sent_inc;
                aw_q[s] <= 1'b1;
              end else if (halve_f) begin
                fail_q[s] <= fail_inc >> 1;
                sent_q[s] <= sent_q[s] >> 1;
                succ_q[s] <= succ_q[s] >> 1;
                dly_q[s]  <= dly_q[s] >> 1;
              end else begin
                fail_q[s] <= fail_inc;
              end
            end
          end
          epst_pkg::CMD_REPLY: begin
            if (w_q.item.echo_type == 8'd0 && w_q.valid_slot &&
                lseq_q[s] == w_q.item.echo_seq && tgt_q[s] == w_q.item.ip_addr && aw_q[s]) begin
              aw_q[s] <= 1'b0;
              if (halve_r) begin
                dly_q[s]  <= dsum >> 1;
                succ_q[s] <= succ_inc >> 1;
                sent_q[s] <= sent_q[s] >> 1;
                fail_q[s] <= fail_q[s] >> 1;
              end else begin
                dly_q[s]  <= dsum;
                succ_q[s] <= succ_inc;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/echo_probe_stats_table_unit.sv =====
// Echo probe statistics table. An accepted item passes the front queue and the
// back part's idle, execute and output states before its result is readable; a
// query of a slot in use also runs two passes of the one-bit-a-cycle divider.
// The back part handles one item at a time and waits while its result is unread;
// a two-entry queue decouples input. Reset is asynchronous and clears all slot
// statistics, registers to defaults. Depends on epst_pkg, epst_front, epst_back.
module echo_probe_stats_table_unit #(
  parameter int unsigned MaxSlots = epst_pkg::MaxSlotsDefault,
  parameter int unsigned HalveAt  = epst_pkg::HalveAtDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  epst_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output epst_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i
);

  logic [3:0]  active_q;
  logic [15:0] base_q, period_q, spread_q;
  logic [3:0]  n_used;
  logic        q_valid, q_pop;
  epst_pkg::work_t q_data;

  assign n_used = (active_q > 4'(MaxSlots)) ? 4'(MaxSlots) : active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= epst_pkg::ResetActive;
      base_q   <= 16'd0;
      period_q <= epst_pkg::ResetPeriod;
      spread_q <= epst_pkg::ResetSpread;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        epst_pkg::REG_ACTIVE: active_q <= cfg_data_i[3:0];
        epst_pkg::REG_BASE:   base_q   <= cfg_data_i;
        epst_pkg::REG_PERIOD: period_q <= cfg_data_i;
        epst_pkg::REG_SPREAD: spread_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  epst_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .in_item_i(in_item_i), .n_used_i(n_used), .base_id_i(base_q),
    .q_valid_o(q_valid), .q_data_o(q_data), .q_pop_i(q_pop)
  );

  epst_back #(.MaxSlots(MaxSlots), .HalveAt(HalveAt)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .q_valid_i(q_valid), .q_data_i(q_data),
    .q_pop_o(q_pop), .n_used_i(n_used), .base_id_i(base_q), .period_i(period_q),
    .spread_i(spread_q), .empty(empty), .pop(pop), .out_item_o(out_item_o)
  );

endmodule
